>>> hw/rtl/ffa_pkg.sv
`timescale 1ns / 1ps
package ffa_pkg;
  localparam int unsigned AW = 20;
  localparam int unsigned SW = 2;
  localparam logic [SW-1:0] ST_GRANTED = 2'd0;
  localparam logic [SW-1:0] ST_NOFIT = 2'd1;
  localparam logic [SW-1:0] ST_FULL = 2'd2;
  localparam logic [AW-1:0] HEAP_BASE_RST = 20'h10000;
  localparam logic [AW-1:0] HEAP_SIZE_RST = 20'hD0000;
  localparam logic CFG_HEAP_BASE = 1'b0;
  localparam logic CFG_HEAP_SIZE = 1'b1;

  typedef struct packed {
    logic [AW-1:0] start;
    logic [AW-1:0] len;
  } blk_t;

  typedef struct packed {
    logic   shift;
    logic   init;
    logic   load;
    blk_t   load_blk;
  } cell_ctl_t;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_APPLY = 4'b0100,
    S_OUT   = 4'b1000
  } state_t;
endpackage

>>> hw/rtl/ffa_cell.sv
`timescale 1ns / 1ps
module ffa_cell (
  input  logic              clk,
  input  ffa_pkg::cell_ctl_t ctl,
  input  ffa_pkg::blk_t     init_blk,
  input  ffa_pkg::blk_t     from_next,
  output ffa_pkg::blk_t     blk
);
  import ffa_pkg::*;
  blk_t blk_r;
  // shift: entries move toward index 0 (from_next); entry 0 wraps around to the tail
  always_ff @(posedge clk) begin
    if (ctl.init) begin
      blk_r <= init_blk;
    end else if (ctl.load) begin
      blk_r <= ctl.load_blk;
    end else if (ctl.shift) begin
      blk_r <= from_next;
    end
  end
  assign blk = blk_r;
endmodule

>>> hw/rtl/first_fit_aligned_allocator.sv
`timescale 1ns / 1ps
// channel | direction | payload
// in_     | input     | in_req_size
// out_    | output    | out_status, out_alloc_addr, out_granted_size
// Each request steps through accept (S_IDLE), a scan that rotates the cell ring once past
// cell 0 (S_SCAN), apply (S_APPLY) and result (S_OUT); new requests wait until S_OUT is left.
// Reset and every cfg write restore the single heap block.
// The result sits in an output register; out_stall holds it and blocks new requests.
module first_fit_aligned_allocator #(
  parameter int unsigned MAX_FREE_BLOCKS = 16,
  parameter int unsigned ALIGN_SHIFT = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [ffa_pkg::AW-1:0]     in_req_size,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [ffa_pkg::SW-1:0]     out_status,
  output logic [ffa_pkg::AW-1:0]     out_alloc_addr,
  output logic [ffa_pkg::AW-1:0]     out_granted_size,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [ffa_pkg::AW-1:0]     cfg_wdata
);
  import ffa_pkg::*;
  localparam int unsigned N = MAX_FREE_BLOCKS;
  localparam int unsigned IW = $clog2(N);
  localparam int unsigned CW = $clog2(N + 1);
  localparam logic [AW:0] AMASK = (AW+1)'((1 << ALIGN_SHIFT) - 1);

  state_t state_r, state_nxt;
  logic [AW-1:0] base_r, size_r;
  logic [CW-1:0] cnt_r;
  logic [IW-1:0] pos_r;    // original index of the current head
  logic          found_r;
  logic [IW-1:0] sel_r;
  logic [AW:0]   rsize_r;
  logic [AW-1:0] alig_r;
  logic          drop_r, app_r;
  blk_t          upd_r, rem_r;
  logic [SW-1:0] st_r;
  logic [AW-1:0] addr_r, gsize_r;

  blk_t      blks [N];
  blk_t      head, init0;
  logic      init_all, full, do_apply;

  assign head = blks[0];
  assign init_all = !rst_n || cfg_we;
  assign full = app_r && cnt_r >= CW'(N);
  assign do_apply = state_r == S_APPLY && found_r && !full;

  always_comb begin
    init0 = '{start: base_r, len: size_r};
    if (!rst_n) begin
      init0 = '{start: HEAP_BASE_RST, len: HEAP_SIZE_RST};
    end else if (cfg_we && cfg_index == CFG_HEAP_BASE) begin
      init0.start = cfg_wdata;
    end else if (cfg_we) begin
      init0.len = cfg_wdata;
    end
  end

  // alignment of head entry
  logic [AW:0] hs, hg, hal, rem_len;
  logic        fits, live;
  always_comb begin
    hs = {1'b0, head.start};
    hg = ((AMASK + 1'b1) - (hs & AMASK)) & AMASK;
    hal = hs + hg;
    fits = !hal[AW] && ({1'b0, head.len} >= hg)
           && ({1'b0, head.len} - hg >= rsize_r);
    rem_len = {1'b0, head.len} - hg - rsize_r;
    live = CW'(pos_r) < cnt_r;
  end

  genvar g;
  generate
    for (g = 0; g < N; g++) begin : gen_cell
      localparam logic [IW-1:0] GI = IW'(g);
      localparam logic [CW-1:0] GC = CW'(g);
      blk_t      nxt_in;
      blk_t      ib;
      cell_ctl_t ctl;
      if (g == N - 1) begin : g_tail
        assign nxt_in = blks[0];
      end else begin : g_mid
        assign nxt_in = blks[g+1];
      end
      if (g == 0) begin : g_head
        assign ib = init0;
      end else begin : g_rest
        assign ib = '0;
      end
      always_comb begin
        ctl = '0;
        ctl.init = init_all;
        ctl.shift = state_r == S_SCAN || (do_apply && drop_r && GI >= sel_r);
        ctl.load = do_apply && !drop_r && (GI == sel_r || (app_r && GC == cnt_r));
        ctl.load_blk = (GI == sel_r) ? upd_r : rem_r;
      end
      ffa_cell u_cell (
        .clk(clk), .ctl(ctl), .init_blk(ib), .from_next(nxt_in), .blk(blks[g]));
    end
  endgenerate

  assign in_stall = state_r != S_IDLE;
  assign out_valid = state_r == S_OUT;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_SCAN;
      S_SCAN:  if (pos_r == IW'(N - 1)) state_nxt = S_APPLY;
      S_APPLY: state_nxt = S_OUT;
      S_OUT:   if (!out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      base_r <= HEAP_BASE_RST;
      size_r <= HEAP_SIZE_RST;
      cnt_r <= CW'(1);
      pos_r <= '0;
      found_r <= 1'b0;
      st_r <= ST_NOFIT;
      addr_r <= '0;
      gsize_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        if (cfg_index == CFG_HEAP_BASE) base_r <= cfg_wdata;
        else size_r <= cfg_wdata;
      end
      if (cfg_we) begin
        cnt_r <= CW'(1);
      end else if (do_apply) begin
        if (drop_r) cnt_r <= cnt_r - 1'b1;
        else if (app_r) cnt_r <= cnt_r + 1'b1;
      end
      case (state_r)
        S_IDLE: begin
          pos_r <= '0;
          found_r <= 1'b0;
          if (in_valid) rsize_r <= ({1'b0, in_req_size} + AMASK) & ~AMASK;
        end
        S_SCAN: begin
          pos_r <= pos_r + 1'b1;
          if (!found_r && fits && live) begin
            found_r <= 1'b1;
            sel_r <= pos_r;
            alig_r <= hal[AW-1:0];
            drop_r <= hg == '0 && {1'b0, head.len} == rsize_r;
            app_r <= hg != '0 && rem_len != '0;
            if (hg == '0) begin
              upd_r <= '{start: head.start + rsize_r[AW-1:0],
                         len: head.len - rsize_r[AW-1:0]};
            end else begin
              upd_r <= '{start: head.start, len: hg[AW-1:0]};
            end
            rem_r <= '{start: hal[AW-1:0] + rsize_r[AW-1:0], len: rem_len[AW-1:0]};
          end
        end
        S_APPLY: begin
          if (!found_r) begin
            st_r <= ST_NOFIT;
            addr_r <= '0;
            gsize_r <= '0;
          end else if (full) begin
            st_r <= ST_FULL;
            addr_r <= '0;
            gsize_r <= '0;
          end else begin
            st_r <= ST_GRANTED;
            addr_r <= alig_r;
            gsize_r <= rsize_r[AW-1:0];
          end
        end
        default: ;
      endcase
    end
  end

  assign out_status = st_r;
  assign out_alloc_addr = addr_r;
  assign out_granted_size = gsize_r;
endmodule

>>> hw/rtl/ffa_checker.sv
`timescale 1ns / 1ps
module ffa_checker (
  input logic clk, rst_n, in_valid, in_stall, out_valid, out_stall,
  input logic [ffa_pkg::SW-1:0] out_status,
  input logic [ffa_pkg::AW-1:0] out_alloc_addr, out_granted_size
);
  import ffa_pkg::*;
  a_stat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status == ST_GRANTED || out_status == ST_NOFIT
                  || out_status == ST_FULL) else $error("bad status");
  a_fail0: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_GRANTED |-> out_alloc_addr == '0 && out_granted_size == '0)
    else $error("fail payload");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) && $stable(out_alloc_addr)
                               && $stable(out_granted_size))
    else $error("hold");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("busy");
  a_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall) else $error("take");
endmodule

bind first_fit_aligned_allocator ffa_checker u_chk (.*);

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import ffa_pkg::*;

  localparam int unsigned NBLK = 16;
  localparam int unsigned LAT = 2 * NBLK + 8;
  localparam longint unsigned CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic [SW-1:0] status;
    logic [AW-1:0] addr;
    logic [AW-1:0] size;
  } grant_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [AW-1:0] in_req_size = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [SW-1:0] out_status;
  logic [AW-1:0] out_alloc_addr;
  logic [AW-1:0] out_granted_size;
  logic cfg_we = 1'b0;
  logic cfg_index = CFG_HEAP_BASE;
  logic [AW-1:0] cfg_wdata = '0;

  first_fit_aligned_allocator i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_req_size(in_req_size),
    .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
    .out_alloc_addr(out_alloc_addr), .out_granted_size(out_granted_size),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // allocator shadow
  logic [AW-1:0] heap_base_q, heap_size_q;
  logic [AW-1:0] fl_start [NBLK];
  logic [AW-1:0] fl_len [NBLK];
  int unsigned fl_count;
  grant_t grant_q[$];
  int errors = 0;
  longint unsigned cycles = 0;
  bit stall_busy = 1'b0;

  function automatic int gap_len(int hi);
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, hi);
  endfunction

  task automatic table_reinit();
    fl_start[0] = heap_base_q;
    fl_len[0] = heap_size_q;
    fl_count = 1;
  endtask

  function automatic grant_t alloc_predict(logic [AW-1:0] req);
    grant_t g;
    logic [AW:0] sz;
    logic [AW:0] gp, al, rem;
    int sel;
    sz = ({1'b0, req} + 21'd15) & ~21'd15;
    sel = -1;
    for (int i = 0; i < fl_count; i++) begin
      gp = (21'd16 - {17'd0, fl_start[i][3:0]}) & 21'd15;
      if ({1'b0, fl_start[i]} + gp > 21'hFFFFF) continue;
      if ({1'b0, fl_len[i]} >= gp && {1'b0, fl_len[i]} - gp >= sz) begin
        sel = i;
        break;
      end
    end
    g = '{ST_NOFIT, '0, '0};
    if (sel < 0) return g;
    gp = (21'd16 - {17'd0, fl_start[sel][3:0]}) & 21'd15;
    al = {1'b0, fl_start[sel]} + gp;
    if (gp == 0) begin
      if ({1'b0, fl_len[sel]} == sz) begin
        for (int i = sel; i + 1 < fl_count; i++) begin
          fl_start[i] = fl_start[i+1];
          fl_len[i] = fl_len[i+1];
        end
        fl_count--;
      end else begin
        fl_start[sel] = fl_start[sel] + sz[AW-1:0];
        fl_len[sel] = fl_len[sel] - sz[AW-1:0];
      end
    end else begin
      rem = {1'b0, fl_len[sel]} - gp - sz;
      if (rem != 0) begin
        if (fl_count >= NBLK) begin
          g.status = ST_FULL;
          return g;
        end
        fl_start[fl_count] = al[AW-1:0] + sz[AW-1:0];
        fl_len[fl_count] = rem[AW-1:0];
        fl_count++;
      end
      fl_len[sel] = gp[AW-1:0];
    end
    g.status = ST_GRANTED;
    g.addr = al[AW-1:0];
    g.size = sz[AW-1:0];
    return g;
  endfunction

  task automatic report_mismatch(string what, logic [AW-1:0] got, logic [AW-1:0] exp);
    $display("mismatch %s: got %0h expected %0h", what, got, exp);
    errors++;
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    grant_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (grant_q.size() == 0) begin
        report_mismatch("unexpected result", AW'(out_status), '0);
      end else begin
        e = grant_q.pop_front();
        if (out_status !== e.status)
          report_mismatch("status", AW'(out_status), AW'(e.status));
        if (out_alloc_addr !== e.addr) report_mismatch("alloc_addr", out_alloc_addr, e.addr);
        if (out_granted_size !== e.size)
          report_mismatch("granted_size", out_granted_size, e.size);
      end
    end
  end

  initial begin
    int n;
    forever begin
      @(negedge clk);
      if (stall_busy && $urandom_range(0, 99) < 30) begin
        n = gap_len(40) + 1;
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_request(logic [AW-1:0] req);
    int n;
    grant_t p;
    n = gap_len(25);
    repeat (n + 1) @(negedge clk);
    in_valid <= 1'b1;
    in_req_size <= req;
    p = alloc_predict(req);
    grant_q = {grant_q, p};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    in_valid <= 1'b0;
    in_req_size <= 20'($urandom());
  endtask

  task automatic drain();
    while (grant_q.size() != 0) @(negedge clk);
    repeat (LAT) @(negedge clk);
  endtask

  task automatic write_heap(logic idx, logic [AW-1:0] val);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_HEAP_BASE) heap_base_q = val;
    else heap_size_q = val;
    table_reinit();
  endtask

  function automatic logic [AW-1:0] rand_req();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 20'($urandom_range(0, 160));
    if (r < 85) return 20'($urandom_range(0, 4096));
    if (r < 95) return 20'($urandom());
    return 20'hFFFF0 | 20'($urandom_range(0, 15));
  endfunction

  task automatic test_directed();
    stall_busy = 1'b0;
    send_request(20'd0);
    send_request(20'd1);
    send_request(20'd16);
    send_request(20'd17);
    send_request(20'hFFFFF);
    send_request(20'hFFFF1);
    send_request(20'hD0000);
    send_request(20'd0);
    write_heap(CFG_HEAP_BASE, 20'h00003);
    write_heap(CFG_HEAP_SIZE, 20'h00040);
    send_request(20'd0);
    send_request(20'd16);
    send_request(20'd45);
    send_request(20'd0);
    write_heap(CFG_HEAP_BASE, 20'hFFFFF);
    send_request(20'd0);
    write_heap(CFG_HEAP_BASE, 20'h00000);
    write_heap(CFG_HEAP_SIZE, 20'h00000);
    send_request(20'd0);
    send_request(20'd0);
    send_request(20'd1);
    write_heap(CFG_HEAP_SIZE, 20'hFFFFF);
    send_request(20'hFFFF0);
    send_request(20'hAAAAA);
    send_request(20'h55555);
  endtask

  // misaligned bases split blocks and fill the table
  task automatic test_fragmentation();
    stall_busy = 1'b1;
    for (int p = 0; p < 6; p++) begin
      write_heap(CFG_HEAP_BASE, 20'($urandom_range(1, 15)) | (20'($urandom()) & 20'h0FFF0));
      write_heap(CFG_HEAP_SIZE, 20'($urandom_range(256, 8192)));
      for (int k = 0; k < 40; k++) begin
        if ($urandom_range(0, 3) == 0) write_heap(CFG_HEAP_BASE,
            fl_start[(fl_count == 0) ? 0 : $urandom_range(0, fl_count - 1)]
            + 20'($urandom_range(1, 15)));
        send_request($urandom_range(0, 3) == 0 ? 20'($urandom_range(0, 15))
                                               : 20'($urandom_range(0, 300)));
      end
    end
  endtask

  task automatic test_random();
    stall_busy = 1'b1;
    for (int p = 0; p < 8; p++) begin
      write_heap(CFG_HEAP_BASE, 20'($urandom()));
      write_heap(CFG_HEAP_SIZE, (p % 2) ? 20'($urandom()) : 20'($urandom_range(0, 2048)));
      for (int k = 0; k < 55; k++) send_request(rand_req());
    end
    write_heap(CFG_HEAP_BASE, HEAP_BASE_RST);
    write_heap(CFG_HEAP_SIZE, HEAP_SIZE_RST);
    for (int k = 0; k < 20; k++) send_request(rand_req());
  endtask

  initial begin
    heap_base_q = HEAP_BASE_RST;
    heap_size_q = HEAP_SIZE_RST;
    table_reinit();
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_fragmentation();
    test_random();
    drain();
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
